// ===== rtl/dfspn_pkg.sv =====
// ----------------------------------------------------------------------------
// dfspn_pkg
// Shared types and codes of the depth-first preorder numbering block.
// ----------------------------------------------------------------------------
package dfspn_pkg;

   // Vertex fields are four bits wide, so no more than sixteen vertices are used.
   localparam int VERTEX_LIMIT = 16;
   localparam logic [4:0] NUM_VERTICES_RESET = 5'd16;

   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_EDGE   = 2'd1;
   localparam logic [1:0] MODE_RUN    = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [2:0] STATUS_STORED   = 3'd0;
   localparam logic [2:0] STATUS_IGNORED  = 3'd1;
   localparam logic [2:0] STATUS_OVERFLOW = 3'd2;
   localparam logic [2:0] STATUS_CLEARED  = 3'd3;
   localparam logic [2:0] STATUS_ENTRY    = 3'd4;

   typedef logic [3:0] vertex_type;

   typedef struct packed {
      logic [1:0] mode;
      vertex_type src_vertex;
      vertex_type dst_vertex;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      vertex_type vertex_id;
      logic [3:0] preorder;
      logic       last;
   } rsp_type;

   // Commands from the controller to the graph memories.
   typedef struct packed {
      logic       clear;
      logic       deg_rd;
      logic       edge_wr;
      logic       nbr_rd;
      vertex_type deg_rd_vertex;
      vertex_type edge_src;
      vertex_type edge_dst;
      vertex_type nbr_rd_vertex;
   } graph_cmd_type;

   // Commands from the controller to the stack and preorder memories.
   typedef struct packed {
      logic       push;
      logic       pop;
      logic       pre_wr;
      logic       pre_rd;
      vertex_type push_vertex;
      vertex_type pre_wr_vertex;
      logic [3:0] pre_wr_value;
      vertex_type pre_rd_vertex;
   } walk_cmd_type;

endpackage

// ===== rtl/dfspn_graph_store.sv =====
// ----------------------------------------------------------------------------
// dfspn_graph_store
// Degree counts and neighbour lists, each in a synchronous memory with a
// registered read port. Degree entries carry valid bits so that a single clear
// empties every list.
// ----------------------------------------------------------------------------
module dfspn_graph_store #(
   parameter int CAP        = 16,
   parameter int MAX_DEGREE = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dfspn_pkg::graph_cmd_type             cmd,
   input  logic [$clog2(MAX_DEGREE+1)-1:0]      edge_deg,
   input  logic [$clog2(MAX_DEGREE+1)-1:0]      nbr_rd_idx,
   output logic [$clog2(MAX_DEGREE+1)-1:0]      deg_out,
   output dfspn_pkg::vertex_type                nbr_out
);

   localparam int VW  = $clog2(CAP);
   localparam int DW  = $clog2(MAX_DEGREE + 1);
   localparam int NAW = $clog2(CAP * MAX_DEGREE);

   logic [DW-1:0]               deg_mem_ff [CAP];
   logic [CAP-1:0]              deg_vld_ff;
   logic [CAP-1:0]              deg_vld_in;
   logic [DW-1:0]               deg_rd_ff;
   logic                        deg_rd_vld_ff;
   dfspn_pkg::vertex_type       nbr_mem_ff [CAP * MAX_DEGREE];
   dfspn_pkg::vertex_type       nbr_rd_ff;
   logic [NAW-1:0]              nbr_wr_addr;
   logic [NAW-1:0]              nbr_rd_addr;

   assign nbr_wr_addr = NAW'(NAW'(cmd.edge_src[VW-1:0]) * NAW'(MAX_DEGREE)) + NAW'(edge_deg);
   assign nbr_rd_addr = NAW'(NAW'(cmd.nbr_rd_vertex[VW-1:0]) * NAW'(MAX_DEGREE))
                      + NAW'(nbr_rd_idx);

   always_comb begin
      deg_vld_in = deg_vld_ff;
      if (cmd.clear) begin
         deg_vld_in = '0;
      end else if (cmd.edge_wr) begin
         deg_vld_in[cmd.edge_src[VW-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deg_vld_ff <= '0;
      end else begin
         deg_vld_ff <= deg_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.edge_wr) begin
         deg_mem_ff[cmd.edge_src[VW-1:0]] <= DW'(edge_deg + 1'b1);
         nbr_mem_ff[nbr_wr_addr]           <= cmd.edge_dst;
      end
      if (cmd.deg_rd) begin
         deg_rd_ff     <= deg_mem_ff[cmd.deg_rd_vertex[VW-1:0]];
         deg_rd_vld_ff <= deg_vld_ff[cmd.deg_rd_vertex[VW-1:0]];
      end
      if (cmd.nbr_rd) begin
         nbr_rd_ff <= nbr_mem_ff[nbr_rd_addr];
      end
   end

   // A vertex whose list was never filled since the last clear has degree zero.
   assign deg_out = deg_rd_vld_ff ? deg_rd_ff : '0;
   assign nbr_out = nbr_rd_ff;

endmodule

// ===== rtl/dfspn_walk_store.sv =====
// ----------------------------------------------------------------------------
// dfspn_walk_store
// Walk stack frames and preorder numbers, each in a synchronous memory with
// a registered read port.
// ----------------------------------------------------------------------------
module dfspn_walk_store #(
   parameter int CAP        = 16,
   parameter int MAX_DEGREE = 8
) (
   input  logic                                 clock,
   input  dfspn_pkg::walk_cmd_type              cmd,
   input  logic [$clog2(CAP)-1:0]               stack_addr,
   input  logic [$clog2(MAX_DEGREE+1)-1:0]      push_idx,
   input  logic [$clog2(MAX_DEGREE+1)-1:0]      push_deg,
   output dfspn_pkg::vertex_type                pop_vertex,
   output logic [$clog2(MAX_DEGREE+1)-1:0]      pop_idx,
   output logic [$clog2(MAX_DEGREE+1)-1:0]      pop_deg,
   output logic [3:0]                           pre_out
);

   localparam int VW = $clog2(CAP);
   localparam int DW = $clog2(MAX_DEGREE + 1);
   localparam int FW = 4 + 2 * DW;

   logic [FW-1:0] stack_mem_ff [CAP];
   logic [FW-1:0] stack_rd_ff;
   logic [3:0]    pre_mem_ff [CAP];
   logic [3:0]    pre_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem_ff[stack_addr] <= {cmd.push_vertex, push_idx, push_deg};
      end
      if (cmd.pop) begin
         stack_rd_ff <= stack_mem_ff[stack_addr];
      end
      if (cmd.pre_wr) begin
         pre_mem_ff[cmd.pre_wr_vertex[VW-1:0]] <= cmd.pre_wr_value;
      end
      if (cmd.pre_rd) begin
         pre_rd_ff <= pre_mem_ff[cmd.pre_rd_vertex[VW-1:0]];
      end
   end

   assign pop_vertex = stack_rd_ff[FW-1 -: 4];
   assign pop_idx    = stack_rd_ff[2*DW-1 -: DW];
   assign pop_deg    = stack_rd_ff[DW-1:0];
   assign pre_out    = pre_rd_ff;

endmodule

// ===== rtl/dfs_preorder_numbering.sv =====
// ----------------------------------------------------------------------------
// dfs_preorder_numbering
// Stores a directed graph from edge items and numbers its vertices in
// depth-first preorder on a run item.
//
//   channel  ports                         direction  transfer
//   request  start, busy, req_data         in         start high, busy low
//   result   rsp_valid, rsp_data           out        every cycle rsp_valid high
//   config   csr_valid, csr_ready, csr_data in        csr_valid and csr_ready high
//
// A clear item and an ignored edge are answered straight from idle; an unused
// mode gets no result. A stored or dropped edge waits for the registered read of
// the degree memory. In a run each discovery, neighbour fetch and stack pop waits
// one memory read, and the entries of the vertices in use stream out one per
// cycle at the end.
// Reset is synchronous and empties the graph at once through valid bits.
// The receiver cannot stall, so results never wait inside the block.
// ----------------------------------------------------------------------------
module dfs_preorder_numbering #(
   parameter int MAX_VERTICES = 16,
   parameter int MAX_DEGREE   = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  dfspn_pkg::req_type   req_data,
   output logic                 rsp_valid,
   output dfspn_pkg::rsp_type   rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [4:0]           csr_data
);

   localparam int CAP = (MAX_VERTICES < dfspn_pkg::VERTEX_LIMIT) ? MAX_VERTICES
                                                                : dfspn_pkg::VERTEX_LIMIT;
   localparam int VW  = $clog2(CAP);
   localparam int DW  = $clog2(MAX_DEGREE + 1);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_EDGE = 8'b0000_0010,
      S_ROOT = 8'b0000_0100,
      S_DEG  = 8'b0000_1000,
      S_STEP = 8'b0001_0000,
      S_NBR  = 8'b0010_0000,
      S_POP  = 8'b0100_0000,
      S_EMIT = 8'b1000_0000
   } state_type;

   state_type                  state_ff, state_in;
   logic [4:0]                 num_ff, num_in;
   logic [4:0]                 n_act;
   logic [4:0]                 root_ff, root_in;
   logic [4:0]                 emit_ff, emit_in;
   logic [3:0]                 counter_ff, counter_in;
   logic [CAP-1:0]             visited_ff, visited_in;
   logic [VW-1:0]              depth_ff, depth_in;
   dfspn_pkg::vertex_type      top_v_ff, top_v_in;
   logic [DW-1:0]              top_idx_ff, top_idx_in;
   logic [DW-1:0]              top_deg_ff, top_deg_in;
   dfspn_pkg::vertex_type      src_ff, src_in;
   dfspn_pkg::vertex_type      dst_ff, dst_in;
   logic                       emit_pend_ff, emit_pend_in;
   dfspn_pkg::vertex_type      emit_vid_ff, emit_vid_in;
   logic                       emit_last_ff, emit_last_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   dfspn_pkg::rsp_type         rsp_ff, rsp_in;
   logic                       accept;

   dfspn_pkg::graph_cmd_type   gcmd;
   dfspn_pkg::walk_cmd_type    wcmd;
   logic [VW-1:0]              stack_addr;
   logic [DW-1:0]              deg_out;
   dfspn_pkg::vertex_type      nbr_out;
   dfspn_pkg::vertex_type      pop_vertex;
   logic [DW-1:0]              pop_idx;
   logic [DW-1:0]              pop_deg;
   logic [3:0]                 pre_out;

   dfspn_graph_store #(
      .CAP        (CAP),
      .MAX_DEGREE (MAX_DEGREE)
   ) u_graph (
      .clock      (clock),
      .reset      (reset),
      .cmd        (gcmd),
      .edge_deg   (deg_out),
      .nbr_rd_idx (top_idx_ff),
      .deg_out    (deg_out),
      .nbr_out    (nbr_out)
   );

   dfspn_walk_store #(
      .CAP        (CAP),
      .MAX_DEGREE (MAX_DEGREE)
   ) u_walk (
      .clock      (clock),
      .cmd        (wcmd),
      .stack_addr (stack_addr),
      .push_idx   (top_idx_ff),
      .push_deg   (top_deg_ff),
      .pop_vertex (pop_vertex),
      .pop_idx    (pop_idx),
      .pop_deg    (pop_deg),
      .pre_out    (pre_out)
   );

   // The count in use is the register clamped to one up to the vertex capacity.
   assign n_act = (num_ff == 5'd0) ? 5'd1 : ((num_ff > 5'(CAP)) ? 5'(CAP) : num_ff);

   assign busy      = (state_ff != S_IDLE) || emit_pend_ff;
   assign accept    = start && !busy;
   // A register write never shares an edge with an item transfer.
   assign csr_ready = !busy && !start;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      num_in       = num_ff;
      root_in      = root_ff;
      emit_in      = emit_ff;
      counter_in   = counter_ff;
      visited_in   = visited_ff;
      depth_in     = depth_ff;
      top_v_in     = top_v_ff;
      top_idx_in   = top_idx_ff;
      top_deg_in   = top_deg_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      emit_pend_in = 1'b0;
      emit_vid_in  = emit_vid_ff;
      emit_last_in = emit_last_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      gcmd         = '0;
      wcmd         = '0;
      stack_addr   = depth_ff;

      if (csr_valid && csr_ready) begin
         num_in = csr_data;
      end

      // Preorder read data lands in the cycle after the read was issued.
      if (emit_pend_ff) begin
         rsp_valid_in     = 1'b1;
         rsp_in.status    = dfspn_pkg::STATUS_ENTRY;
         rsp_in.vertex_id = emit_vid_ff;
         rsp_in.preorder  = pre_out;
         rsp_in.last      = emit_last_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in.vertex_id = '0;
               rsp_in.preorder  = '0;
               rsp_in.last      = 1'b1;
               if (req_data.mode == dfspn_pkg::MODE_CLEAR) begin
                  gcmd.clear    = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = dfspn_pkg::STATUS_CLEARED;
               end else if (req_data.mode == dfspn_pkg::MODE_EDGE) begin
                  if (({1'b0, req_data.src_vertex} >= n_act) ||
                      ({1'b0, req_data.dst_vertex} >= n_act)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = dfspn_pkg::STATUS_IGNORED;
                  end else begin
                     gcmd.deg_rd        = 1'b1;
                     gcmd.deg_rd_vertex = req_data.src_vertex;
                     src_in             = req_data.src_vertex;
                     dst_in             = req_data.dst_vertex;
                     state_in           = S_EDGE;
                  end
               end else if (req_data.mode == dfspn_pkg::MODE_RUN) begin
                  visited_in = '0;
                  counter_in = '0;
                  root_in    = '0;
                  depth_in   = '0;
                  state_in   = S_ROOT;
               end
            end
         end
         S_EDGE: begin
            rsp_valid_in     = 1'b1;
            rsp_in.vertex_id = '0;
            rsp_in.preorder  = '0;
            rsp_in.last      = 1'b1;
            if (deg_out >= DW'(MAX_DEGREE)) begin
               rsp_in.status = dfspn_pkg::STATUS_OVERFLOW;
            end else begin
               gcmd.edge_wr  = 1'b1;
               gcmd.edge_src = src_ff;
               gcmd.edge_dst = dst_ff;
               rsp_in.status = dfspn_pkg::STATUS_STORED;
            end
            state_in = S_IDLE;
         end
         S_ROOT: begin
            if (root_ff == n_act) begin
               emit_in  = '0;
               state_in = S_EMIT;
            end else if (visited_ff[root_ff[VW-1:0]]) begin
               root_in = 5'(root_ff + 1'b1);
            end else begin
               visited_in[root_ff[VW-1:0]] = 1'b1;
               wcmd.pre_wr        = 1'b1;
               wcmd.pre_wr_vertex = root_ff[3:0];
               wcmd.pre_wr_value  = counter_ff;
               counter_in         = 4'(counter_ff + 1'b1);
               gcmd.deg_rd        = 1'b1;
               gcmd.deg_rd_vertex = root_ff[3:0];
               top_v_in           = root_ff[3:0];
               state_in           = S_DEG;
            end
         end
         S_DEG: begin
            top_deg_in = deg_out;
            top_idx_in = '0;
            state_in   = S_STEP;
         end
         S_STEP: begin
            if (top_idx_ff >= top_deg_ff) begin
               if (depth_ff == '0) begin
                  root_in  = 5'(root_ff + 1'b1);
                  state_in = S_ROOT;
               end else begin
                  wcmd.pop   = 1'b1;
                  stack_addr = VW'(depth_ff - 1'b1);
                  depth_in   = VW'(depth_ff - 1'b1);
                  state_in   = S_POP;
               end
            end else begin
               gcmd.nbr_rd        = 1'b1;
               gcmd.nbr_rd_vertex = top_v_ff;
               top_idx_in         = DW'(top_idx_ff + 1'b1);
               state_in           = S_NBR;
            end
         end
         S_NBR: begin
            // A neighbour at or above the count in use is a stale entry and is skipped.
            if (({1'b0, nbr_out} < n_act) && !visited_ff[nbr_out[VW-1:0]]) begin
               wcmd.push          = 1'b1;
               wcmd.push_vertex   = top_v_ff;
               depth_in           = VW'(depth_ff + 1'b1);
               visited_in[nbr_out[VW-1:0]] = 1'b1;
               wcmd.pre_wr        = 1'b1;
               wcmd.pre_wr_vertex = nbr_out;
               wcmd.pre_wr_value  = counter_ff;
               counter_in         = 4'(counter_ff + 1'b1);
               gcmd.deg_rd        = 1'b1;
               gcmd.deg_rd_vertex = nbr_out;
               top_v_in           = nbr_out;
               state_in           = S_DEG;
            end else begin
               state_in = S_STEP;
            end
         end
         S_POP: begin
            top_v_in   = pop_vertex;
            top_idx_in = pop_idx;
            top_deg_in = pop_deg;
            state_in   = S_STEP;
         end
         S_EMIT: begin
            wcmd.pre_rd        = 1'b1;
            wcmd.pre_rd_vertex = emit_ff[3:0];
            emit_pend_in       = 1'b1;
            emit_vid_in        = emit_ff[3:0];
            emit_last_in       = (5'(emit_ff + 1'b1) == n_act);
            if (5'(emit_ff + 1'b1) == n_act) begin
               state_in = S_IDLE;
            end else begin
               emit_in = 5'(emit_ff + 1'b1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         num_ff       <= dfspn_pkg::NUM_VERTICES_RESET;
         emit_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         depth_ff     <= '0;
         visited_ff   <= '0;
         counter_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         num_ff       <= num_in;
         emit_pend_ff <= emit_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         depth_ff     <= depth_in;
         visited_ff   <= visited_in;
         counter_ff   <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      root_ff      <= root_in;
      emit_ff      <= emit_in;
      top_v_ff     <= top_v_in;
      top_idx_ff   <= top_idx_in;
      top_deg_ff   <= top_deg_in;
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      emit_vid_ff  <= emit_vid_in;
      emit_last_ff <= emit_last_in;
      rsp_ff       <= rsp_in;
   end

endmodule

// ===== rtl/dfspn_checker.sv =====
// ----------------------------------------------------------------------------
// dfspn_checker
// Port-level checks of the preorder numbering block, bound to its top level.
// ----------------------------------------------------------------------------
module dfspn_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input dfspn_pkg::req_type req_data,
   input logic               rsp_valid,
   input dfspn_pkg::rsp_type rsp_data
);

   // After reset the block is idle and shows no result.
   a_reset_idle: assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

   // A clear transfer answers in the very next cycle as the only result.
   a_clear_answer: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.mode == dfspn_pkg::MODE_CLEAR)
      |=> rsp_valid && (rsp_data.status == dfspn_pkg::STATUS_CLEARED) && rsp_data.last)
      else $error("clear transfer not answered in the next cycle");

   // Results other than preorder entries carry zero fields and close their item.
   a_plain_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != dfspn_pkg::STATUS_ENTRY)
      |-> (rsp_data.vertex_id == 4'd0) && (rsp_data.preorder == 4'd0) && rsp_data.last)
      else $error("edge or clear result with stray fields");

   // Preorder entries stream without gaps in ascending vertex order.
   a_entry_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == dfspn_pkg::STATUS_ENTRY) && !rsp_data.last
      |=> rsp_valid && (rsp_data.status == dfspn_pkg::STATUS_ENTRY)
          && (rsp_data.vertex_id == 4'($past(rsp_data.vertex_id) + 1'b1)))
      else $error("preorder entries out of sequence");

endmodule

bind dfs_preorder_numbering dfspn_checker u_dfspn_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
